### sv/canonical_decimal_int_parser_macros.svh
// Assertion macros shared by the checker of the decimal parser.
// No dependencies; included by the files that assert.
`ifndef CANONICAL_DECIMAL_INT_PARSER_MACROS_SVH
`define CANONICAL_DECIMAL_INT_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CDIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdip: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define CDIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdip: next-cycle check failed");

`endif

### sv/cdip_pkg.sv
// Types and constants for the canonical decimal integer parser.
// No dependencies; used by every module of the block.
`default_nettype none

package cdip_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam int unsigned ValW  = 64;
  localparam int unsigned ProdW = ValW + 4;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_EMPTY        = 3'd1,
    ERR_BAD_CHAR     = 3'd2,
    ERR_LEADING_ZERO = 3'd3,
    ERR_OVERFLOW     = 3'd4
  } err_kind_t;

  typedef struct packed {
    logic              mode_signed;
    logic [ValW-1:0]   magnitude;
    logic              is_negative;
    logic              digit_seen;
    logic              first_zero;
    err_kind_t         err;
    logic              char_seen;
    logic              text_open;
  } parse_state_t;

  typedef struct packed {
    logic            ok;
    logic [ValW-1:0] value;
    err_kind_t       err;
  } parse_result_t;

endpackage

`default_nettype wire

### sv/cdip_step.sv
// One-word parse step: next parser state and the result for a closing word.
// Depends on cdip_pkg.
`default_nettype none

module cdip_step (
  input  cdip_pkg::parse_state_t  state_i,
  input  logic                    op,
  input  logic [7:0]              char_code,
  input  logic                    start_req,
  input  logic                    last,
  input  logic                    no_char,
  output cdip_pkg::parse_state_t  state_o,
  output cdip_pkg::parse_result_t result_o
);
  import cdip_pkg::*;

  parse_state_t    base;
  parse_state_t    taken;
  logic            first;
  logic            is_digit;
  logic [3:0]      digit;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] limit;
  err_kind_t       fin_err;

  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit    = 4'(char_code - CHAR_ZERO);

  // mag*10 + d, wide enough that it cannot wrap
  assign prod = ({4'd0, base.magnitude} << 3) + ({4'd0, base.magnitude} << 1)
              + {{(ProdW-4){1'b0}}, digit};

  always_comb begin
    if (!base.mode_signed) begin
      limit = {4'd0, {ValW{1'b1}}};
    end else if (base.is_negative) begin
      limit = {{(ProdW-ValW){1'b0}}, 1'b1, {(ValW-1){1'b0}}};
    end else begin
      limit = {{(ProdW-ValW+1){1'b0}}, {(ValW-1){1'b1}}};
    end
  end

  always_comb begin
    base = state_i;
    if (start_req || !state_i.text_open) begin
      base.magnitude   = '0;
      base.is_negative = 1'b0;
      base.digit_seen  = 1'b0;
      base.first_zero  = 1'b0;
      base.err         = ERR_NONE;
      base.char_seen   = 1'b0;
      base.mode_signed = op;
      base.text_open   = 1'b1;
    end
  end

  assign first = !base.char_seen;

  always_comb begin
    taken = base;
    if (!no_char) begin
      taken.char_seen = 1'b1;
      priority if (base.err != ERR_NONE) begin
        taken.err = base.err;
      end else if (first && base.mode_signed && char_code == CHAR_MINUS) begin
        taken.is_negative = 1'b1;
      end else if (base.digit_seen && base.first_zero) begin
        taken.err = ERR_LEADING_ZERO;
      end else if (!is_digit) begin
        taken.err = ERR_BAD_CHAR;
      end else begin
        if (!base.digit_seen) begin
          taken.digit_seen = 1'b1;
          taken.first_zero = (digit == 4'd0);
        end
        if (prod > limit) begin
          taken.err = ERR_OVERFLOW;
        end else begin
          taken.magnitude = prod[ValW-1:0];
        end
      end
    end
  end

  always_comb begin
    fin_err = taken.err;
    if (taken.err == ERR_NONE) begin
      priority if (!taken.char_seen) begin
        fin_err = ERR_EMPTY;
      end else if (!taken.digit_seen) begin
        fin_err = ERR_BAD_CHAR;
      end else if (taken.is_negative && taken.magnitude == '0) begin
        fin_err = ERR_LEADING_ZERO;
      end else begin
        fin_err = ERR_NONE;
      end
    end
  end

  always_comb begin
    result_o.err   = fin_err;
    result_o.ok    = (fin_err == ERR_NONE);
    result_o.value = '0;
    if (fin_err == ERR_NONE) begin
      result_o.value = taken.is_negative ? (~taken.magnitude + 64'd1) : taken.magnitude;
    end
  end

  // a closing word leaves the text closed and cleared; mode is kept
  always_comb begin
    state_o = taken;
    if (last) begin
      state_o.magnitude   = '0;
      state_o.is_negative = 1'b0;
      state_o.digit_seen  = 1'b0;
      state_o.first_zero  = 1'b0;
      state_o.err         = ERR_NONE;
      state_o.char_seen   = 1'b0;
      state_o.text_open   = 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/canonical_decimal_int_parser.sv
// Top level of the strict decimal text to 64-bit integer parser.
// Depends on cdip_pkg and cdip_step.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  op, char_code, start_req, last, no_char
//   out_     out  out_valid/out_stall ok, value, error_kind
//
// One word per cycle while in_stall is low: a word is registered, then one parse step
// (multiply by ten, add digit, limit compare) updates the state.
// A closing word's parse step writes its result into the result register.
// in_stall rises only when a closing word waits for a full result register.
// rst_n (synchronous) clears the text state and both valid flags.
`default_nettype none

module canonical_decimal_int_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_char_code,
  input  logic        in_start_req,
  input  logic        in_last,
  input  logic        in_no_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [63:0] out_value,
  output logic [2:0]  out_error_kind
);
  import cdip_pkg::*;

  logic          s1_valid_r;
  logic          s1_op_r;
  logic [7:0]    s1_char_r;
  logic          s1_start_r;
  logic          s1_last_r;
  logic          s1_no_char_r;

  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t result_nxt;

  logic          out_valid_r;
  parse_result_t out_r;

  logic          out_free;
  logic          s1_go;
  logic          in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && s1_last_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  cdip_step u_step (
    .state_i   (state_r),
    .op        (s1_op_r),
    .char_code (s1_char_r),
    .start_req (s1_start_r),
    .last      (s1_last_r),
    .no_char   (s1_no_char_r),
    .state_o   (state_nxt),
    .result_o  (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r      <= in_op;
      s1_char_r    <= in_char_code;
      s1_start_r   <= in_start_req;
      s1_last_r    <= in_last;
      s1_no_char_r <= in_no_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_r.ok;
  assign out_value      = out_r.value;
  assign out_error_kind = out_r.err;

endmodule

`default_nettype wire

### sv/cdip_checker.sv
// Port-level checks for the decimal parser, bound to its top level.
// Depends on cdip_pkg and canonical_decimal_int_parser_macros.svh.
`default_nettype none
`include "canonical_decimal_int_parser_macros.svh"

module cdip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_ok,
  input logic [63:0] out_value,
  input logic [2:0]  out_error_kind
);
  import cdip_pkg::*;

  // held word on a stalled result port
  `CDIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_ok) && $stable(out_error_kind))

  `CDIP_ASSERT_NOW(a_ok_no_err, clk, rst_n, out_valid && out_ok, out_error_kind == ERR_NONE)

  // failure carries a real kind and a zero value
  `CDIP_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && !out_ok, out_value == 64'd0 && out_error_kind != ERR_NONE)

  `CDIP_ASSERT_NOW(a_kind_range, clk, rst_n, out_valid, out_error_kind == ERR_NONE || out_error_kind == ERR_EMPTY || out_error_kind == ERR_BAD_CHAR || out_error_kind == ERR_LEADING_ZERO || out_error_kind == ERR_OVERFLOW)

endmodule

bind canonical_decimal_int_parser cdip_checker u_cdip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ok         (out_ok),
  .out_value      (out_value),
  .out_error_kind (out_error_kind)
);

`default_nettype wire
